// ----- hw/rtl/rlfp_pkg.sv -----
package rlfp_pkg;

  // Frame geometry and packet layout.
  localparam int LED_COUNT       = 24;
  localparam int RING_LEDS       = 18;
  localparam int ROWS_PER_COLUMN = 28;
  localparam int COLUMNS         = 3;
  localparam int MAP_COLS        = 3;
  localparam int MAP_ROWS        = 28;

  localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int RING_FILL = (RING_LEDS < LED_COUNT) ? RING_LEDS : LED_COUNT;
  localparam int STEP_W    = $clog2(ROWS_PER_COLUMN + 2);
  localparam int MAP_ROW_W = $clog2(MAP_ROWS);
  localparam int MAP_COL_W = 2;
  localparam int ROW_W     = (STEP_W > MAP_ROW_W) ? STEP_W : MAP_ROW_W;
  localparam int COLOR_W   = 24;

  localparam logic [7:0] WRITE_CMD  = 8'h80;
  localparam logic [7:0] COL_STRIDE = 8'h20;

  // Queue depths.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Item function codes.
  localparam logic [1:0] FUNC_PUT       = 2'd0;
  localparam logic [1:0] FUNC_FILL_ALL  = 2'd1;
  localparam logic [1:0] FUNC_FILL_RING = 2'd2;
  localparam logic [1:0] FUNC_SEND      = 2'd3;

  // Internal command codes.
  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_SEND = 2'd2;

  // Channel codes within one LED row.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Packet row to LED index and channel.
  localparam logic [4:0] MAP_LED [MAP_COLS][MAP_ROWS] = '{
    '{5'd18, 5'd18, 5'd18, 5'd23, 5'd23, 5'd23, 5'd14, 5'd14, 5'd14, 5'd11,
      5'd11, 5'd11, 5'd16, 5'd16, 5'd16, 5'd2,  5'd2,  5'd2,  5'd8,  5'd8,
      5'd8,  5'd0,  5'd0,  5'd5,  5'd5,  5'd5,  5'd0,  5'd0},
    '{5'd19, 5'd19, 5'd19, 5'd22, 5'd22, 5'd22, 5'd13, 5'd13, 5'd13, 5'd10,
      5'd10, 5'd10, 5'd17, 5'd17, 5'd17, 5'd1,  5'd1,  5'd1,  5'd7,  5'd7,
      5'd7,  5'd0,  5'd0,  5'd4,  5'd4,  5'd4,  5'd0,  5'd0},
    '{5'd20, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd12, 5'd12, 5'd12, 5'd9,
      5'd9,  5'd9,  5'd15, 5'd15, 5'd15, 5'd0,  5'd0,  5'd0,  5'd6,  5'd6,
      5'd6,  5'd0,  5'd0,  5'd3,  5'd3,  5'd3,  5'd0,  5'd0}
  };

  // The channel pattern is the same for every column.
  localparam logic [1:0] MAP_CH [MAP_ROWS] = '{
    CH_RED, CH_BLUE, CH_GREEN, CH_RED, CH_BLUE, CH_GREEN, CH_RED, CH_GREEN,
    CH_BLUE, CH_BLUE, CH_GREEN, CH_RED, CH_RED, CH_GREEN, CH_BLUE, CH_RED,
    CH_GREEN, CH_BLUE, CH_RED, CH_GREEN, CH_BLUE, CH_RED, CH_RED, CH_RED,
    CH_GREEN, CH_BLUE, CH_RED, CH_RED
  };

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  first_led;
    logic [7:0]  run_length;
    logic [7:0]  run_position;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [1:0]  column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } out_item_t;

  // For a put, led_idx is the target LED; for a fill, the last LED written.
  typedef struct packed {
    logic [1:0]           op;
    logic [LED_W-1:0]     led_idx;
    logic [COLOR_W-1:0]   color;
    logic [MAP_COL_W-1:0] col;
  } cmd_t;

endpackage

// ----- hw/rtl/rlfp_ram.sv -----
module rlfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/rlfp_front.sv -----
module rlfp_front (
  input  logic              push,
  input  rlfp_pkg::in_item_t in_item,
  output logic              full,
  input  logic              cmd_full,
  output logic              cmd_push,
  output rlfp_pkg::cmd_t    cmd
);
  import rlfp_pkg::*;

  logic [8:0] run_end;
  logic [7:0] led_sum;
  logic       put_ok;
  logic       send_ok;
  logic       keep;

  // Range checks for a put-color run and for a send column.
  assign run_end = {1'b0, in_item.first_led} + {1'b0, in_item.run_length};
  assign led_sum = in_item.first_led + in_item.run_position;
  assign put_ok  = ({1'b0, in_item.first_led} < 9'(LED_COUNT)) &&
                   (run_end <= 9'(LED_COUNT)) &&
                   (in_item.run_position < in_item.run_length);
  assign send_ok = (4'(in_item.column) < 4'(COLUMNS)) &&
                   (4'(in_item.column) < 4'(MAP_COLS));

  // Turn the item into a command, or drop it when it has no effect.
  always_comb begin
    keep        = 1'b0;
    cmd.op      = OP_PUT;
    cmd.led_idx = LED_W'(led_sum);
    cmd.color   = {in_item.blue[14:7], in_item.green[14:7], in_item.red[14:7]};
    cmd.col     = in_item.column;
    case (in_item.func)
      FUNC_PUT: begin
        keep = put_ok;
      end
      FUNC_FILL_ALL: begin
        keep        = 1'b1;
        cmd.op      = OP_FILL;
        cmd.led_idx = LED_W'(LED_COUNT - 1);
        cmd.color   = {in_item.blue[7:0], in_item.green[7:0], in_item.red[7:0]};
      end
      FUNC_FILL_RING: begin
        keep        = 1'b1;
        cmd.op      = OP_FILL;
        cmd.led_idx = LED_W'(RING_FILL - 1);
        cmd.color   = {in_item.blue[7:0], in_item.green[7:0], in_item.red[7:0]};
      end
      FUNC_SEND: begin
        keep   = send_ok;
        cmd.op = OP_SEND;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && keep;

endmodule

// ----- hw/rtl/rlfp_cmd_fifo.sv -----
module rlfp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_push,
  input  rlfp_pkg::cmd_t cmd_in,
  output logic           cmd_full,
  input  logic           cmd_pop,
  output logic           cmd_valid,
  output rlfp_pkg::cmd_t cmd_out
);
  import rlfp_pkg::*;

  cmd_t                 slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [CMD_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign cmd_full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_out   = slot_r[rptr_r];
  assign do_push   = cmd_push && !cmd_full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Pointer and occupancy update.
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= cmd_in;
    end
  end

endmodule

// ----- hw/rtl/rlfp_back.sv -----
module rlfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  rlfp_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                pop,
  output logic                empty,
  output rlfp_pkg::out_item_t out_item
);
  import rlfp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [LED_W-1:0]     cnt_r, cnt_nxt;
  logic [LED_W-1:0]     fill_last_r, fill_last_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic [MAP_COL_W-1:0] col_r, col_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [LED_COUNT-1:0] vld_r, vld_nxt;

  // Byte stage between the memory read and the output queue.
  logic       pend_r, pend_nxt;
  logic       pend_ram_r, pend_ram_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic [1:0] pend_ch_r, pend_ch_nxt;
  logic [7:0] pend_const_r, pend_const_nxt;
  logic       pend_last_r, pend_last_nxt;

  // Output queue.
  out_item_t            oq_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owptr_r, orptr_r;
  logic [OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                 o_pop;
  out_item_t            o_wr;

  // Frame store port signals.
  logic                 wr_en;
  logic [LED_W-1:0]     wr_addr;
  logic [COLOR_W-1:0]   wr_data;
  logic                 rd_en;
  logic [LED_W-1:0]     rd_addr;
  logic [COLOR_W-1:0]   rd_data;

  logic                 room;
  logic [ROW_W-1:0]     row;
  logic [4:0]           map_led;
  logic [7:0]           ch_byte;

  rlfp_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign room    = (ocnt_r + OUT_CNT_W'(pend_r)) < OUT_CNT_W'(OUT_DEPTH);
  assign row     = ROW_W'(step_r) - ROW_W'(2);
  assign map_led = MAP_LED[col_r][row[MAP_ROW_W-1:0]];
  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;

  // Sequencer: takes one command and carries it out.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_last_nxt  = fill_last_r;
    color_nxt      = color_r;
    col_nxt        = col_r;
    step_nxt       = step_r;
    vld_nxt        = vld_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r;
    wr_data        = color_r;
    rd_en          = 1'b0;
    rd_addr        = LED_W'(map_led);
    pend_nxt       = 1'b0;
    pend_ram_nxt   = 1'b0;
    pend_vld_nxt   = 1'b0;
    pend_ch_nxt    = MAP_CH[row[MAP_ROW_W-1:0]];
    pend_const_nxt = 8'd0;
    pend_last_nxt  = (step_r == STEP_W'(ROWS_PER_COLUMN + 1));
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_PUT: begin
              wr_en                = 1'b1;
              wr_addr              = cmd.led_idx;
              wr_data              = cmd.color;
              vld_nxt[cmd.led_idx] = 1'b1;
            end
            OP_FILL: begin
              cnt_nxt       = '0;
              fill_last_nxt = cmd.led_idx;
              color_nxt     = cmd.color;
              state_nxt     = ST_FILL;
            end
            OP_SEND: begin
              col_nxt   = cmd.col;
              step_nxt  = '0;
              state_nxt = ST_SEND;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        wr_en          = 1'b1;
        vld_nxt[cnt_r] = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == fill_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (room) begin
          pend_nxt = 1'b1;
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_W'(0)) begin
            pend_const_nxt = WRITE_CMD;
          end else if (step_r == STEP_W'(1)) begin
            pend_const_nxt = 8'(col_r) * COL_STRIDE;
          end else if ((row < ROW_W'(MAP_ROWS)) &&
                       (7'(map_led) < 7'(LED_COUNT))) begin
            rd_en        = 1'b1;
            pend_ram_nxt = 1'b1;
            pend_vld_nxt = vld_r[LED_W'(map_led)];
          end
          if (pend_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Channel pick from the row that the store read in the cycle before.
  always_comb begin
    case (pend_ch_r)
      CH_RED:   ch_byte = rd_data[7:0];
      CH_GREEN: ch_byte = rd_data[15:8];
      CH_BLUE:  ch_byte = rd_data[23:16];
      default:  ch_byte = 8'd0;
    endcase
    if (pend_ram_r) begin
      o_wr.packet_byte = pend_vld_r ? (ch_byte >> 2) : 8'd0;
    end else begin
      o_wr.packet_byte = pend_const_r;
    end
    o_wr.last_byte = pend_last_r;
  end

  // Output queue control.
  assign empty    = (ocnt_r == '0);
  assign out_item = oq_r[orptr_r];
  assign o_pop    = pop && !empty;
  assign ocnt_nxt = ocnt_r + OUT_CNT_W'(pend_r) - OUT_CNT_W'(o_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      pend_r  <= 1'b0;
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      pend_r  <= pend_nxt;
      owptr_r <= pend_r ? owptr_r + 1'b1 : owptr_r;
      orptr_r <= o_pop ? orptr_r + 1'b1 : orptr_r;
      ocnt_r  <= ocnt_nxt;
    end
  end

  // Working registers and queue storage.
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    fill_last_r  <= fill_last_nxt;
    color_r      <= color_nxt;
    col_r        <= col_nxt;
    step_r       <= step_nxt;
    pend_ram_r   <= pend_ram_nxt;
    pend_vld_r   <= pend_vld_nxt;
    pend_ch_r    <= pend_ch_nxt;
    pend_const_r <= pend_const_nxt;
    pend_last_r  <= pend_last_nxt;
    if (pend_r) begin
      oq_r[owptr_r] <= o_wr;
    end
  end

endmodule

// ----- hw/rtl/rgb_led_frame_remap_packetizer.sv -----
// RGB frame store of 24 LEDs with a column packetizer. Items enter a two-deep
// command queue after classification, so the input side keeps accepting while
// earlier work is carried out. The back end takes each command from the queue
// while it is idle; a put-color item is written in the same cycle as its
// command is taken. A fill then writes the LEDs in turn in the fill state, all
// 24 for fill-all and the first 18 for fill-ring, since the store is one RAM
// row per LED with a single write port. A send-column item issues 30 packet
// bytes from the store's single read port, one byte a cycle while the result
// queue has room. Each byte passes the byte stage registers and is written to
// the result queue that feeds the result ports; the back end keeps that pace
// while the consumer pops every cycle, and a four-entry result queue absorbs
// stalls on the result side. Items that have no effect are dropped at the
// front without using the back end. The store reads as zero after reset
// through per-LED valid bits, so no clearing pass is needed.
module rgb_led_frame_remap_packetizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rlfp_pkg::in_item_t  in_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output rlfp_pkg::out_item_t out_item
);
  import rlfp_pkg::*;

  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;

  // Front end: accepts and classifies each transaction.
  rlfp_front u_front (
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Queue between the front and back ends.
  rlfp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_push  (cmd_push),
    .cmd_in    (cmd_in),
    .cmd_full  (cmd_full),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd_out   (cmd_out)
  );

  // Back end: frame store updates and packet generation.
  rlfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
